@@ hw/rtl/hmac_md5_engine_unit_defines.svh @@
// Assertion macros for the HMAC-MD5 engine.
// Included by RTL files that carry concurrent checks; needs aclk and aresetn in scope.
`ifndef HMAC_MD5_ENGINE_UNIT_DEFINES_SVH
`define HMAC_MD5_ENGINE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HMD5_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define HMD5_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define HMD5_ASSERT(lbl, prop, msg)
`define HMD5_ASSERT_NR(lbl, prop, msg)
`endif
`endif

@@ hw/rtl/hmd5_pkg.sv @@
// Shared types, constants and MD5 round tables for the HMAC-MD5 engine.
// No dependencies.
`default_nettype none
package hmd5_pkg;

    localparam int KEY_BYTES = 64;
    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5c;
    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [127:0] MD5_IV =
        128'h67452301_efcdab89_98badcfe_10325476;

    typedef struct packed {
        logic       start;
        logic       feed;
        logic       finish;
        logic [7:0] data;
    } md5_cmd_t;

    function automatic logic [31:0] md5_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
            4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
            4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
            4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; 4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md5_g(input logic [5:0] r);
        logic [3:0] t;
        logic [3:0] g;
        t = r[3:0];
        case (r[5:4])
            2'd0: g = t;
            2'd1: g = 4'(t * 4'd5) + 4'd1;
            2'd2: g = 4'(t * 4'd3) + 4'd5;
            2'd3: g = 4'(t * 4'd7);
            default: g = t;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Byte i of a digest in output order; word 0 sits in bits 127:96.
    function automatic logic [7:0] digest_byte(input logic [127:0] d, input logic [3:0] i);
        logic [127:0] sh;
        logic [31:0]  w;
        sh = d >> {2'd3 - i[3:2], 5'b0};
        w  = sh[31:0] >> {i[1:0], 3'b0};
        return w[7:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hmd5_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hmd5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/hmd5_md5.sv @@
// MD5 engine: block buffer, byte counter, padding sequencer and one shared round unit.
// Depends on hmd5_pkg.
`default_nettype none
module hmd5_md5 (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire hmd5_pkg::md5_cmd_t cmd,
    output logic                   busy,
    output logic [127:0]           digest
);
    import hmd5_pkg::*;

    typedef enum logic [4:0] {
        M_IDLE  = 5'b00001,
        M_RUN   = 5'b00010,
        M_ADD   = 5'b00100,
        M_PZERO = 5'b01000,
        M_PLEN  = 5'b10000
    } mstate_t;

    mstate_t     state_reg, state_next, ret_reg, ret_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [31:0] wa_next, wb_next, wc_next, wd_next;
    logic [31:0] buf_reg [16];
    logic [63:0] count_reg, count_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [5:0]  pos;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [31:0] f, sum;

    assign pos    = count_reg[5:0];
    assign busy   = (state_reg != M_IDLE);
    assign digest = {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3]};

    always_comb begin
        case (rnd_reg[5:4])
            2'd0: f = (wb_reg & wc_reg) | (~wb_reg & wd_reg);
            2'd1: f = (wd_reg & wb_reg) | (~wd_reg & wc_reg);
            2'd2: f = wb_reg ^ wc_reg ^ wd_reg;
            2'd3: f = wc_reg ^ (wb_reg | ~wd_reg);
            default: f = 32'h0;
        endcase
        sum = wa_reg + f + md5_k(rnd_reg) + buf_reg[md5_g(rnd_reg)];
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        count_next = count_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        wa_next    = wa_reg;
        wb_next    = wb_reg;
        wc_next    = wc_reg;
        wd_next    = wd_reg;
        for (int i = 0; i < 4; i++) begin
            chain_next[i] = chain_reg[i];
        end
        wr_en   = 1'b0;
        wr_byte = 8'h00;
        case (state_reg)
            M_IDLE: begin
                if (cmd.start) begin
                    for (int i = 0; i < 4; i++) begin
                        chain_next[i] = MD5_IV[127 - 32*i -: 32];
                    end
                    count_next = '0;
                end else if (cmd.feed) begin
                    wr_en   = 1'b1;
                    wr_byte = cmd.data;
                end else if (cmd.finish) begin
                    len_next   = {count_reg[60:0], 3'b000};
                    wr_en      = 1'b1;
                    wr_byte    = PAD_MARK;
                    state_next = M_PZERO;
                end
            end
            M_PZERO: begin
                if (pos == 6'd56) begin
                    state_next = M_PLEN;
                end else begin
                    wr_en = 1'b1;
                end
            end
            M_PLEN: begin
                wr_en   = 1'b1;
                wr_byte = len_reg[{pos[2:0], 3'b000} +: 8];
            end
            M_RUN: begin
                wa_next  = wd_reg;
                wd_next  = wc_reg;
                wc_next  = wb_reg;
                wb_next  = wb_reg + rotl32(sum, md5_s(rnd_reg));
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = M_ADD;
                end
            end
            M_ADD: begin
                chain_next[0] = chain_reg[0] + wa_reg;
                chain_next[1] = chain_reg[1] + wb_reg;
                chain_next[2] = chain_reg[2] + wc_reg;
                chain_next[3] = chain_reg[3] + wd_reg;
                state_next    = ret_reg;
            end
            default: state_next = M_IDLE;
        endcase
        if (wr_en) begin
            count_next = count_reg + 64'd1;
            if (pos == 6'd63) begin
                wa_next    = chain_reg[0];
                wb_next    = chain_reg[1];
                wc_next    = chain_reg[2];
                wd_next    = chain_reg[3];
                rnd_next   = '0;
                ret_next   = (state_reg == M_PLEN) ? M_IDLE : state_next;
                state_next = M_RUN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            ret_reg   <= M_IDLE;
            count_reg <= '0;
            rnd_reg   <= '0;
            for (int i = 0; i < 4; i++) begin
                chain_reg[i] <= MD5_IV[127 - 32*i -: 32];
            end
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            count_reg <= count_next;
            rnd_reg   <= rnd_next;
            for (int i = 0; i < 4; i++) begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        wa_reg  <= wa_next;
        wb_reg  <= wb_next;
        wc_reg  <= wc_next;
        wd_reg  <= wd_next;
        len_reg <= len_next;
        if (wr_en) begin
            buf_reg[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/hmac_md5_engine_unit.sv @@
// HMAC-MD5 engine top level: key store, item sequencer and result register.
// Depends on hmd5_pkg, hmd5_ram, hmd5_md5 and hmac_md5_engine_unit_defines.svh.
//
// Streams a key (action 0) and then messages (action 1), one byte per beat, and returns
// HMAC-MD5 of each message as two 64-bit beats when its last beat arrives. The block takes
// one beat at a time: s_ready drops while a beat is worked. Every 64 hashed bytes pass
// through the single shared MD5 round unit (64 rounds and the chain add). A message byte
// goes through the sequencer states accept, dispatch, feed and dispatch. Key-store sweeps
// (long key, inner and outer pad) read each byte through the key RAM read port and then
// feed it. Opening a message runs the inner-pad sweep; closing it finishes the inner hash,
// runs the outer-pad sweep, hashes the inner digest and finishes the outer hash.
`default_nettype none
`include "hmac_md5_engine_unit_defines.svh"
module hmac_md5_engine_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_byte_present,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_digest_half,
    output logic             m_half_index,
    output logic             m_last_half
);
    import hmd5_pkg::*;

    localparam int AW = $clog2(KEY_BYTES);

    typedef enum logic [14:0] {
        C_IDLE  = 15'b000000000000001,
        C_DISP  = 15'b000000000000010,
        C_SWRD  = 15'b000000000000100,
        C_SWFD  = 15'b000000000001000,
        C_FEED  = 15'b000000000010000,
        C_KFIN  = 15'b000000000100000,
        C_KWAIT = 15'b000000001000000,
        C_KWR   = 15'b000000010000000,
        C_MFIN  = 15'b000000100000000,
        C_MWAIT = 15'b000001000000000,
        C_INNER = 15'b000010000000000,
        C_OFIN  = 15'b000100000000000,
        C_OWAIT = 15'b001000000000000,
        C_OUT0  = 15'b010000000000000,
        C_OUT1  = 15'b100000000000000
    } cstate_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_KEY  = 3'b010,
        PH_MSG  = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        SW_LONG = 3'b001,
        SW_IPAD = 3'b010,
        SW_OPAD = 3'b100
    } sweep_t;

    cstate_t        cst_reg, cst_next;
    phase_t         phase_reg, phase_next;
    sweep_t         kind_reg, kind_next;
    logic           act_reg, pres_reg, lst_reg, bdone_reg, bdone_next;
    logic [7:0]     v_reg;
    logic [6:0]     klen_reg, klen_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [KEY_BYTES-1:0] kvalid_reg;
    logic           rdv_reg;
    logic [127:0]   inner_reg, out_reg;
    logic           kv_clr, kv_set;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata, ram_rdata, key_rd, pad;
    logic           inner_load, out_load;
    md5_cmd_t       cmd;
    logic           md5_busy;
    logic [127:0]   md5_digest;

    hmd5_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    hmd5_md5 u_md5 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .busy    (md5_busy),
        .digest  (md5_digest)
    );

    assign s_ready       = (cst_reg == C_IDLE);
    assign m_valid       = (cst_reg == C_OUT0) || (cst_reg == C_OUT1);
    assign m_half_index  = (cst_reg == C_OUT1);
    assign m_last_half   = (cst_reg == C_OUT1);
    assign m_digest_half = (cst_reg == C_OUT1) ?
        {bswap32(out_reg[63:32]), bswap32(out_reg[31:0])} :
        {bswap32(out_reg[127:96]), bswap32(out_reg[95:64])};

    assign key_rd = rdv_reg ? ram_rdata : 8'h00;

    always_comb begin
        case (kind_reg)
            SW_IPAD: pad = IPAD_BYTE;
            SW_OPAD: pad = OPAD_BYTE;
            default: pad = 8'h00;
        endcase
    end

    always_comb begin
        cst_next   = cst_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        bdone_next = bdone_reg;
        klen_next  = klen_reg;
        idx_next   = idx_reg;
        kv_clr     = 1'b0;
        kv_set     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = digest_byte(md5_digest, idx_reg[3:0]);
        inner_load = 1'b0;
        out_load   = 1'b0;
        cmd        = '0;
        case (cst_reg)
            C_IDLE: begin
                if (s_valid) begin
                    bdone_next = 1'b0;
                    cst_next   = C_DISP;
                    if (!s_action && phase_reg != PH_KEY) begin
                        kv_clr     = 1'b1;
                        klen_next  = '0;
                        phase_next = PH_KEY;
                    end
                end
            end
            C_DISP: begin
                if (!act_reg) begin
                    if (phase_reg != PH_KEY) begin
                        cst_next = C_IDLE;
                    end else if (!bdone_reg && pres_reg) begin
                        if (klen_reg < 7'(KEY_BYTES)) begin
                            ram_we     = 1'b1;
                            ram_waddr  = klen_reg[AW-1:0];
                            ram_wdata  = v_reg;
                            kv_set     = 1'b1;
                            klen_next  = klen_reg + 7'd1;
                            bdone_next = 1'b1;
                        end else if (klen_reg == 7'(KEY_BYTES)) begin
                            if (!md5_busy) begin
                                cmd.start = 1'b1;
                                kind_next = SW_LONG;
                                idx_next  = '0;
                                cst_next  = C_SWRD;
                            end
                        end else begin
                            cst_next = C_FEED;
                        end
                    end else if (lst_reg) begin
                        if (klen_reg > 7'(KEY_BYTES)) begin
                            cst_next = C_KFIN;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end else begin
                        cst_next = C_IDLE;
                    end
                end else begin
                    if (phase_reg == PH_KEY) begin
                        if (klen_reg > 7'(KEY_BYTES)) begin
                            cst_next = C_KFIN;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end else if (phase_reg != PH_MSG) begin
                        if (!md5_busy) begin
                            cmd.start = 1'b1;
                            kind_next = SW_IPAD;
                            idx_next  = '0;
                            cst_next  = C_SWRD;
                        end
                    end else if (!bdone_reg && pres_reg) begin
                        cst_next = C_FEED;
                    end else if (lst_reg) begin
                        cst_next = C_MFIN;
                    end else begin
                        cst_next = C_IDLE;
                    end
                end
            end
            C_SWRD: begin
                cst_next = C_SWFD;
            end
            C_SWFD: begin
                if (!md5_busy) begin
                    cmd.feed = 1'b1;
                    cmd.data = key_rd ^ pad;
                    idx_next = idx_reg + AW'(1);
                    if (idx_reg == AW'(KEY_BYTES - 1)) begin
                        case (kind_reg)
                            SW_LONG: cst_next = C_FEED;
                            SW_IPAD: begin
                                phase_next = PH_MSG;
                                cst_next   = C_DISP;
                            end
                            SW_OPAD: cst_next = C_INNER;
                            default: cst_next = C_DISP;
                        endcase
                    end else begin
                        cst_next = C_SWRD;
                    end
                end
            end
            C_FEED: begin
                if (!md5_busy) begin
                    cmd.feed   = 1'b1;
                    cmd.data   = v_reg;
                    bdone_next = 1'b1;
                    if (!act_reg && klen_reg == 7'(KEY_BYTES)) begin
                        klen_next = klen_reg + 7'd1;
                    end
                    cst_next = C_DISP;
                end
            end
            C_KFIN: begin
                if (!md5_busy) begin
                    cmd.finish = 1'b1;
                    cst_next   = C_KWAIT;
                end
            end
            C_KWAIT: begin
                if (!md5_busy) begin
                    kv_clr   = 1'b1;
                    idx_next = '0;
                    cst_next = C_KWR;
                end
            end
            C_KWR: begin
                ram_we   = 1'b1;
                kv_set   = 1'b1;
                idx_next = idx_reg + AW'(1);
                if (idx_reg[3:0] == 4'hf) begin
                    idx_next   = '0;
                    phase_next = PH_IDLE;
                    cst_next   = C_DISP;
                end
            end
            C_MFIN: begin
                if (!md5_busy) begin
                    cmd.finish = 1'b1;
                    cst_next   = C_MWAIT;
                end
            end
            C_MWAIT: begin
                if (!md5_busy) begin
                    inner_load = 1'b1;
                    cmd.start  = 1'b1;
                    kind_next  = SW_OPAD;
                    idx_next   = '0;
                    cst_next   = C_SWRD;
                end
            end
            C_INNER: begin
                if (!md5_busy) begin
                    cmd.feed = 1'b1;
                    cmd.data = digest_byte(inner_reg, idx_reg[3:0]);
                    idx_next = idx_reg + AW'(1);
                    if (idx_reg[3:0] == 4'hf) begin
                        idx_next = '0;
                        cst_next = C_OFIN;
                    end
                end
            end
            C_OFIN: begin
                if (!md5_busy) begin
                    cmd.finish = 1'b1;
                    cst_next   = C_OWAIT;
                end
            end
            C_OWAIT: begin
                if (!md5_busy) begin
                    out_load = 1'b1;
                    cst_next = C_OUT0;
                end
            end
            C_OUT0: begin
                if (m_ready) begin
                    cst_next = C_OUT1;
                end
            end
            C_OUT1: begin
                if (m_ready) begin
                    phase_next = PH_IDLE;
                    cst_next   = C_IDLE;
                end
            end
            default: cst_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cst_reg    <= C_IDLE;
            phase_reg  <= PH_IDLE;
            kind_reg   <= SW_LONG;
            bdone_reg  <= 1'b0;
            klen_reg   <= '0;
            idx_reg    <= '0;
            kvalid_reg <= '0;
            inner_reg  <= '0;
        end else begin
            cst_reg   <= cst_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            bdone_reg <= bdone_next;
            klen_reg  <= klen_next;
            idx_reg   <= idx_next;
            if (kv_clr) begin
                kvalid_reg <= '0;
            end else if (kv_set) begin
                kvalid_reg[ram_waddr] <= 1'b1;
            end
            if (inner_load) begin
                inner_reg <= md5_digest;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rdv_reg <= kvalid_reg[idx_reg];
        if (s_valid && s_ready) begin
            act_reg  <= s_action;
            v_reg    <= s_data_byte;
            pres_reg <= s_byte_present;
            lst_reg  <= s_last;
        end
        if (out_load) begin
            out_reg <= md5_digest;
        end
    end

    `HMD5_ASSERT(a_cmd_idle, (cmd.start || cmd.feed || cmd.finish) |-> !md5_busy, "cmd while busy")
    `HMD5_ASSERT(a_accept_drop, (s_valid && s_ready) |=> !s_ready, "ready held after accept")
    `HMD5_ASSERT(a_out_excl, m_valid |-> !s_ready, "input open during result")
    `HMD5_ASSERT_NR(a_rst_out, !aresetn |=> !m_valid, "result valid after reset")

endmodule
`default_nettype wire

@@ sim/tb_hmac_md5_engine_unit.sv @@
// Testbench for hmac_md5_engine_unit: streams keys and messages, predicts HMAC-MD5 digests.
// Depends on hmd5_pkg (key size, pad bytes, MD5 initial value) and the engine RTL.
`timescale 1ns / 1ps
module tb_hmac_md5_engine_unit;
    import hmd5_pkg::*;

    localparam logic ACT_KEY = 1'b0;
    localparam logic ACT_MSG = 1'b1;
    localparam int CYCLE_LIMIT = 6000000;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_KEY  = 3'b010,
        ST_MSG  = 3'b100
    } hm_state_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data;
        logic       present;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [63:0] half;
        logic        index;
        logic        last_half;
    } half_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = 1'b0;
    logic [7:0] s_data_byte = 8'd0;
    logic s_byte_present = 1'b0;
    logic s_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [63:0] m_digest_half;
    logic m_half_index;
    logic m_last_half;

    hmac_md5_engine_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_data_byte(s_data_byte), .s_byte_present(s_byte_present), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_digest_half(m_digest_half),
        .m_half_index(m_half_index), .m_last_half(m_last_half)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    logic [7:0]  key_mem [64];
    logic [7:0]  blk [64];
    logic [31:0] cv [4];
    logic [63:0] nbytes;
    int          key_len;
    hm_state_t   hstate;

    beat_t beat_q[$];
    half_t digest_q[$];
    int    errors = 0;
    int    cycles = 0;
    int    idle_pct = 0;
    int    stall_pct = 0;
    bit    hold_send = 1'b0;

    function automatic logic [31:0] rl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] m [16];
        logic [31:0] a, b, c, d, f, t;
        int g, sh;
        int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        logic [31:0] kt [64] = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
            32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
            32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
            32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
            32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
            32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
            32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
            32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
            32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
            32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        for (int i = 0; i < 16; i++)
            m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                f = (b & c) | (~b & d); g = i;
            end else if (i < 32) begin
                f = (d & b) | (~d & c); g = (5 * i + 1) & 15;
            end else if (i < 48) begin
                f = b ^ c ^ d; g = (3 * i + 5) & 15;
            end else begin
                f = c ^ (b | ~d); g = (7 * i) & 15;
            end
            sh = shifts[(i >> 4) * 4 + (i & 3)];
            t = d; d = c; c = b;
            b = b + rl(a + f + kt[i] + m[g], sh);
            a = t;
        end
        cv[0] += a; cv[1] += b; cv[2] += c; cv[3] += d;
    endtask

    task automatic hash_start();
        {cv[0], cv[1], cv[2], cv[3]} = MD5_IV;
        nbytes = 64'd0;
    endtask

    task automatic hash_byte(input logic [7:0] v);
        blk[nbytes[5:0]] = v;
        nbytes++;
        if (nbytes[5:0] == 6'd0) compress();
    endtask

    task automatic hash_end(output logic [7:0] dg [16]);
        int pos;
        logic [63:0] bits;
        pos = nbytes[5:0];
        bits = nbytes << 3;
        blk[pos++] = PAD_MARK;
        if (pos > 56) begin
            while (pos < 64) blk[pos++] = 8'h00;
            compress();
            pos = 0;
        end
        while (pos < 56) blk[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) blk[56 + i] = bits[8*i +: 8];
        compress();
        for (int i = 0; i < 16; i++) dg[i] = cv[i >> 2][8*(i & 3) +: 8];
    endtask

    task automatic key_finish();
        logic [7:0] dg [16];
        if (key_len > KEY_BYTES) begin
            hash_end(dg);
            for (int i = 0; i < 64; i++) key_mem[i] = (i < 16) ? dg[i] : 8'h00;
        end
        hstate = ST_IDLE;
    endtask

    task automatic predict_beat(input beat_t bt);
        logic [7:0] idg [16];
        logic [7:0] odg [16];
        half_t h;
        if (bt.action == ACT_KEY) begin
            if (hstate != ST_KEY) begin
                foreach (key_mem[i]) key_mem[i] = 8'h00;
                key_len = 0;
                hstate = ST_KEY;
            end
            if (bt.present) begin
                if (key_len < KEY_BYTES) begin
                    key_mem[key_len++] = bt.data;
                end else if (key_len == KEY_BYTES) begin
                    hash_start();
                    for (int i = 0; i < 64; i++) hash_byte(key_mem[i]);
                    hash_byte(bt.data);
                    key_len = KEY_BYTES + 1;
                end else begin
                    hash_byte(bt.data);
                end
            end
            if (bt.last) key_finish();
            return;
        end
        if (hstate == ST_KEY) key_finish();
        if (hstate != ST_MSG) begin
            hash_start();
            for (int i = 0; i < 64; i++) hash_byte(key_mem[i] ^ IPAD_BYTE);
            hstate = ST_MSG;
        end
        if (bt.present) hash_byte(bt.data);
        if (bt.last) begin
            hash_end(idg);
            hash_start();
            for (int i = 0; i < 64; i++) hash_byte(key_mem[i] ^ OPAD_BYTE);
            for (int i = 0; i < 16; i++) hash_byte(idg[i]);
            hash_end(odg);
            for (int k = 0; k < 2; k++) begin
                for (int i = 0; i < 8; i++) h.half[63 - 8*i -: 8] = odg[8*k + i];
                h.index = k[0];
                h.last_half = (k == 1);
                digest_q.push_back(h);
            end
            hstate = ST_IDLE;
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
        errors++;
    endtask

    function automatic beat_t mk(input logic act, input logic [7:0] d, input logic p,
                                 input logic l);
        beat_t b;
        b.action = act; b.data = d; b.present = p; b.last = l;
        return b;
    endfunction

    task automatic push_seq(input logic act, input int len, input bit close);
        for (int i = 0; i < len; i++)
            beat_q.push_back(mk(act, 8'($urandom), 1'b1, close && (i == len - 1)));
        if (close && len == 0) beat_q.push_back(mk(act, 8'($urandom), 1'b0, 1'b1));
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_beat({s_action, s_data_byte, s_byte_present, s_last});
            if (!(s_valid && !s_ready)) begin
                if (beat_q.size() != 0 && !hold_send &&
                    $urandom_range(99) >= idle_pct) begin
                    beat_t b;
                    b = beat_q.pop_front();
                    s_valid <= 1'b1;
                    s_action <= b.action;
                    s_data_byte <= b.data;
                    s_byte_present <= b.present;
                    s_last <= b.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    report("unexpected beat", m_digest_half, 64'd0);
                end else begin
                    half_t e;
                    e = digest_q.pop_front();
                    if (m_digest_half !== e.half) report("digest_half", m_digest_half, e.half);
                    if (m_half_index !== e.index) report("half_index", m_half_index, e.index);
                    if (m_last_half !== e.last_half)
                        report("last_half", m_last_half, e.last_half);
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (beat_q.size() != 0 || s_valid || digest_q.size() != 0) @(posedge aclk);
    endtask

    task automatic random_traffic(input int n_beats);
        int target;
        int r;
        target = beat_q.size() + n_beats;
        while (beat_q.size() < target) begin
            r = $urandom_range(99);
            if (r < 15) begin
                // mostly short keys, some past the 64-byte limit
                push_seq(ACT_KEY, ($urandom_range(9) == 0) ? $urandom_range(65, 90)
                                                          : $urandom_range(0, 64), 1'b1);
            end else if (r < 20) begin
                push_seq(ACT_KEY, $urandom_range(1, 10), 1'b0);
            end else if (r < 25) begin
                push_seq(ACT_MSG, $urandom_range(1, 20), 1'b0);
            end else if (r < 30) begin
                beat_q.push_back(mk(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)));
            end else begin
                push_seq(ACT_MSG, ($urandom_range(7) == 0) ? $urandom_range(50, 130)
                                                          : $urandom_range(0, 24), 1'b1);
            end
        end
    endtask

    initial begin
        hstate = ST_IDLE;
        key_len = 0;
        nbytes = 64'd0;
        foreach (key_mem[i]) key_mem[i] = 8'h00;
        foreach (blk[i]) blk[i] = 8'h00;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: message before any key, empty key/message, extremes
        beat_q.push_back(mk(ACT_MSG, 8'hff, 1'b0, 1'b1));
        beat_q.push_back(mk(ACT_MSG, 8'h00, 1'b1, 1'b0));
        beat_q.push_back(mk(ACT_MSG, 8'hff, 1'b1, 1'b1));
        beat_q.push_back(mk(ACT_KEY, 8'h00, 1'b0, 1'b1));
        beat_q.push_back(mk(ACT_MSG, 8'h5a, 1'b1, 1'b1));
        beat_q.push_back(mk(ACT_KEY, 8'hff, 1'b1, 1'b0));
        beat_q.push_back(mk(ACT_KEY, 8'h00, 1'b1, 1'b0));
        beat_q.push_back(mk(ACT_MSG, 8'ha5, 1'b1, 1'b0));   // closes open key
        beat_q.push_back(mk(ACT_MSG, 8'h3c, 1'b0, 1'b0));
        beat_q.push_back(mk(ACT_KEY, 8'h11, 1'b1, 1'b1));   // drops open message
        beat_q.push_back(mk(ACT_MSG, 8'h00, 1'b0, 1'b1));
        push_seq(ACT_KEY, 64, 1'b1);
        push_seq(ACT_MSG, 55, 1'b1);
        push_seq(ACT_MSG, 56, 1'b1);
        push_seq(ACT_KEY, 65, 1'b1);
        push_seq(ACT_MSG, 64, 1'b1);
        wait_drained();

        random_traffic(280);
        wait_drained();
        idle_pct = 57;
        random_traffic(280);
        wait_drained();
        hold_send = 1'b1;
        random_traffic(20);
        repeat (400) @(posedge aclk);
        hold_send = 1'b0;
        idle_pct = 0; stall_pct = 57;
        random_traffic(280);
        wait_drained();
        idle_pct = 38; stall_pct = 38;
        random_traffic(270);
        wait_drained();
        repeat (600) @(posedge aclk);

        if (errors == 0 && digest_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/hmd5_pkg.sv
hw/rtl/hmd5_ram.sv
hw/rtl/hmd5_md5.sv
hw/rtl/hmac_md5_engine_unit.sv
sim/tb_hmac_md5_engine_unit.sv
